@@ design/cds_pkg.sv @@
package cds_pkg;

    localparam int YEAR_BITS  = 14;
    localparam int COUNT_BITS = 16;
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX   = '1;
    localparam logic [YEAR_BITS-1:0] YEAR_RESET = YEAR_BITS'(2000);
    localparam logic [DAY_W-1:0]     DAY_FIRST  = DAY_W'(1);
    localparam logic [DAY_W-1:0]     DAY_LAST   = DAY_W'(31);
    localparam logic [MON_W-1:0]     MON_FIRST  = MON_W'(1);
    localparam logic [MON_W-1:0]     MON_LAST   = MON_W'(12);

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_BACK    = 2'd2;
    localparam logic [1:0] REQ_COMPARE = 2'd3;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [DAY_W-1:0]     op_day;
        logic [MON_W-1:0]     op_month;
        logic [YEAR_BITS-1:0] op_year;
        logic [15:0]          day_count;
    } s_item_t;

    typedef struct packed {
        logic [DAY_W-1:0]     date_day;
        logic [MON_W-1:0]     date_month;
        logic [YEAR_BITS-1:0] date_year;
        logic                 date_valid;
        logic                 is_less;
        logic                 is_equal;
    } m_item_t;

    typedef struct packed {
        logic load_op;
        logic load_date;
        logic step_fwd;
        logic step_back;
        logic cnt_dec;
        logic cap_out;
    } cmd_t;

    typedef struct packed {
        logic in_count_zero;
        logic cnt_is_one;
        logic cnt_is_zero;
        logic back_ok;
    } sts_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W:0] m,
                                                   input logic [YEAR_BITS-1:0] y);
        logic [DAY_W-1:0] len;
        case (m) inside
            5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: len = DAY_W'(31);
            5'd4, 5'd6, 5'd9, 5'd11:                    len = DAY_W'(30);
            5'd2:    len = (y[1:0] == 2'b00) ? DAY_W'(29) : DAY_W'(28);
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic logic date_ok(input logic [DAY_W:0] d, input logic [MON_W:0] m,
                                     input logic [YEAR_BITS-1:0] y);
        return (d != '0) && (d <= {1'b0, month_len(m, y)});
    endfunction

endpackage

@@ design/calendar_date_step.sv @@
// Calendar date counter: holds one date (day, month, year) and serves one
// request per transfer on the s_ channel: load, advance by day_count days,
// step back by day_count days, or compare against the operand date.
// Each request yields exactly one result transfer on the m_ channel with
// the stored date, its validity, and the compare flags (zero unless compare).
// Sequence: a request is taken while idle; advance then steps one day per
// iteration, and step back repeats its single-day walk, skipping invalid
// dates, until each day lands on a valid date. A final state then writes
// the result register. Load, compare and zero-count requests go straight
// from idle to that final state.
// The walk steps the date register through the one-day forward or back units.
// s_ready is low while a request is in progress; the next request is taken
// while a finished result still waits in the output register. When the
// receiver stalls, the next result holds in its final state until the
// output register frees. Synchronous active-low reset sets the date to
// 1 January 2000 and empties the output register.
module calendar_date_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cds_pkg::s_item_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output cds_pkg::m_item_t  m_item
);
    import cds_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cds_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_item.req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    cds_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_item  (m_item),
        .cmd     (cmd),
        .sts     (sts)
    );

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_op, cmd.step_fwd, cmd.step_back, cmd.cap_out}))
        else $error("conflicting datapath commands");

    a_cap_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_out |-> (!m_valid || m_ready))
        else $error("result overwritten before transfer");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous in progress");

    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> !sts.cnt_is_zero)
        else $error("day counter underflow");

endmodule

@@ design/cds_ctrl.sv @@
module cds_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_req_type,
    output logic           m_valid,
    input  logic           m_ready,
    output cds_pkg::cmd_t  cmd,
    input  cds_pkg::sts_t  sts
);
    import cds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FWD  = 4'b0010,
        ST_BACK = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_op   = 1'b1;
                    cmd.load_date = (s_req_type == REQ_LOAD);
                    if (s_req_type == REQ_ADVANCE && !sts.in_count_zero) begin
                        state_next = ST_FWD;
                    end else if (s_req_type == REQ_BACK && !sts.in_count_zero) begin
                        state_next = ST_BACK;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FWD: begin
                cmd.step_fwd = 1'b1;
                cmd.cnt_dec  = 1'b1;
                if (sts.cnt_is_one) begin
                    state_next = ST_FIN;
                end
            end
            ST_BACK: begin
                cmd.step_back = 1'b1;
                if (sts.back_ok) begin
                    cmd.cnt_dec = 1'b1;
                    if (sts.cnt_is_one) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.cap_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.cap_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ design/cds_datapath.sv @@
module cds_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  cds_pkg::s_item_t  s_item,
    output cds_pkg::m_item_t  m_item,
    input  cds_pkg::cmd_t     cmd,
    output cds_pkg::sts_t     sts
);
    import cds_pkg::*;

    logic [DAY_W-1:0]      cur_day_reg, cur_day_next;
    logic [MON_W-1:0]      cur_month_reg, cur_month_next;
    logic [YEAR_BITS-1:0]  cur_year_reg, cur_year_next;

    logic [1:0]            req_reg;
    logic [DAY_W-1:0]      op_day_reg;
    logic [MON_W-1:0]      op_month_reg;
    logic [YEAR_BITS-1:0]  op_year_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    m_item_t               out_reg, out_next;

    logic [DAY_W:0]        fwd_day_inc;
    logic [MON_W:0]        fwd_mon_inc;
    logic [DAY_W-1:0]      fwd_day, back_day;
    logic [MON_W-1:0]      fwd_month, back_month;
    logic [YEAR_BITS-1:0]  fwd_year, back_year;
    logic                  cmp_less, cmp_equal;

    // one day forward
    always_comb begin
        fwd_day_inc = {1'b0, cur_day_reg} + 1'b1;
        fwd_mon_inc = {1'b0, cur_month_reg} + 1'b1;
        fwd_year    = cur_year_reg;
        if (date_ok(fwd_day_inc, {1'b0, cur_month_reg}, cur_year_reg)) begin
            fwd_day   = fwd_day_inc[DAY_W-1:0];
            fwd_month = cur_month_reg;
        end else if (date_ok({{DAY_W{1'b0}}, 1'b1}, fwd_mon_inc, cur_year_reg)) begin
            fwd_day   = DAY_FIRST;
            fwd_month = fwd_mon_inc[MON_W-1:0];
        end else begin
            fwd_day   = DAY_FIRST;
            fwd_month = MON_FIRST;
            if (cur_year_reg != YEAR_MAX) begin
                fwd_year = cur_year_reg + 1'b1;
            end
        end
    end

    // one step back; repeated until the date is valid
    always_comb begin
        back_day   = cur_day_reg - 1'b1;
        back_month = cur_month_reg;
        back_year  = cur_year_reg;
        if (cur_day_reg <= DAY_FIRST) begin
            back_day = DAY_LAST;
            if (cur_month_reg <= MON_FIRST) begin
                back_month = MON_LAST;
                if (cur_year_reg != '0) begin
                    back_year = cur_year_reg - 1'b1;
                end
            end else begin
                back_month = cur_month_reg - 1'b1;
            end
        end
    end

    always_comb begin
        if (cur_year_reg != op_year_reg) begin
            cmp_less = (cur_year_reg < op_year_reg);
        end else if (cur_month_reg != op_month_reg) begin
            cmp_less = (cur_month_reg < op_month_reg);
        end else begin
            cmp_less = (cur_day_reg < op_day_reg);
        end
        cmp_equal = (cur_year_reg == op_year_reg) && (cur_month_reg == op_month_reg)
                    && (cur_day_reg == op_day_reg);
    end

    always_comb begin
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        if (cmd.load_date) begin
            cur_day_next   = s_item.op_day;
            cur_month_next = s_item.op_month;
            cur_year_next  = s_item.op_year;
        end else if (cmd.step_fwd) begin
            cur_day_next   = fwd_day;
            cur_month_next = fwd_month;
            cur_year_next  = fwd_year;
        end else if (cmd.step_back) begin
            cur_day_next   = back_day;
            cur_month_next = back_month;
            cur_year_next  = back_year;
        end
    end

    always_comb begin
        out_next            = out_reg;
        out_next.date_day   = cur_day_reg;
        out_next.date_month = cur_month_reg;
        out_next.date_year  = cur_year_reg;
        out_next.date_valid = date_ok({1'b0, cur_day_reg}, {1'b0, cur_month_reg},
                                      cur_year_reg);
        out_next.is_less    = (req_reg == REQ_COMPARE) && cmp_less;
        out_next.is_equal   = (req_reg == REQ_COMPARE) && cmp_equal;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_day_reg   <= DAY_FIRST;
            cur_month_reg <= MON_FIRST;
            cur_year_reg  <= YEAR_RESET;
        end else begin
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_op) begin
            req_reg      <= s_item.req_type;
            op_day_reg   <= s_item.op_day;
            op_month_reg <= s_item.op_month;
            op_year_reg  <= s_item.op_year;
            cnt_reg      <= s_item.day_count[COUNT_BITS-1:0];
        end else if (cmd.cnt_dec) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.cap_out) begin
            out_reg <= out_next;
        end
    end

    assign sts.in_count_zero = (s_item.day_count[COUNT_BITS-1:0] == '0);
    assign sts.cnt_is_one    = (cnt_reg == COUNT_BITS'(1));
    assign sts.cnt_is_zero   = (cnt_reg == '0);
    assign sts.back_ok       = date_ok({1'b0, back_day}, {1'b0, back_month}, back_year);

    assign m_item = out_reg;

endmodule
